// File: hw/rtl/mss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the Morton split search block
// Field widths, mode codes and the status word of the code comparator.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int IDX_W     = 10;  // width of every table index field
  localparam int CODE_IN_W = 32;  // width of the code field on the input stream

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result of comparing one table code against the first code of a range.
  typedef struct packed {
    logic codes_equal;    // both codes are identical
    logic longer_prefix;  // shares more leading bits than the reference xor
  } mss_cmp_t;

endpackage

// File: hw/rtl/morton_split_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morton_split_search_top: split search over a table of sorted Morton codes
// Stores codes by write items and answers split queries with a binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis group. With tuser low an item writes
//   its code into the table and gives no result. With
//   tuser high it queries the inclusive range [range_first, range_last] and
//   gives one result item on the m_axis group: the split index, with tuser
//   raised when the range is reversed.
//   A query runs on one code comparator and the single read port of the
//   table: it fetches both end codes, then per halving step it forms the
//   probe address, reads the table and compares, skipping the compare when
//   the probe lies at or past the range end, and at last hands the result
//   over. A range of n entries takes about ceil(log2(n)) steps. A reversed
//   range goes straight to the result.
//   s_axis_tready_o is low while a query runs.
//   The result sits in an output register; while the receiver stalls, write
//   items are still taken, and a later query waits at its end until the
//   register is free. Reset empties the output register and returns the
//   sequencer to idle; the table keeps no reset value and must be written
//   before it is read.
// ----------------------------------------------------------------------------
module morton_split_search_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int CODE_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: entry_index[9:0], entry_code[41:10], range_first[51:42],
  // range_last[61:52], zero padding[63:62].
  input  logic [63:0] s_axis_tdata_i,
  // mode
  input  logic        s_axis_tuser_i,
  // Result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: split_index[9:0], zero padding[15:10].
  output logic [15:0] m_axis_tdata_o,
  // range_error
  output logic        m_axis_tuser_o
);
  import mss_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = (CODE_BITS < CODE_IN_W) ? CODE_BITS : CODE_IN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_CMP_END,
    S_STEP,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_DONE
  } state_e;

  // Reduces a table index modulo the depth by conditional subtraction of
  // shifted copies of the depth, largest first.
  function automatic logic [AW-1:0] table_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    int k;
    r = idx;
    if (TABLE_DEPTH < (1 << IDX_W)) begin
      for (k = IDX_W - 1; k >= 0; k--) begin
        if ((TABLE_DEPTH << k) < (1 << IDX_W)) begin
          if (r >= IDX_W'(TABLE_DEPTH << k)) begin
            r = r - IDX_W'(TABLE_DEPTH << k);
          end
        end
      end
    end
    return AW'(r);
  endfunction

  // Input fields
  logic                 in_mode;
  logic [IDX_W-1:0]     in_index;
  logic [CODE_IN_W-1:0] in_code;
  logic [IDX_W-1:0]     in_first;
  logic [IDX_W-1:0]     in_last;

  assign in_mode  = s_axis_tuser_i;
  assign in_index = s_axis_tdata_i[9:0];
  assign in_code  = s_axis_tdata_i[41:10];
  assign in_first = s_axis_tdata_i[51:42];
  assign in_last  = s_axis_tdata_i[61:52];

  state_e           state_q;
  logic [IDX_W-1:0] first_q;
  logic [IDX_W-1:0] last_q;
  logic [IDX_W-1:0] split_q;
  logic [IDX_W-1:0] step_q;
  logic [IDX_W:0]   probe_q;
  logic             err_q;
  logic [SW-1:0]    cfirst_q;
  logic [SW-1:0]    diff_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_split_q;
  logic             out_err_q;

  logic [SW-1:0]    code_mem_q [TABLE_DEPTH];
  logic [SW-1:0]    rdata_q;
  logic             mem_we;
  logic [AW-1:0]    raddr;

  logic             in_fire;
  logic             out_free;
  logic             out_load;
  mss_cmp_t         cmp;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] step_next;
  logic             probe_in_range;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign mem_we          = in_fire && (in_mode == MODE_WRITE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_DONE) && out_free;

  assign mid_sum        = {1'b0, first_q} + {1'b0, last_q};
  assign step_next      = IDX_W'(({1'b0, step_q} + (IDX_W + 1)'(1)) >> 1);
  assign probe_in_range = (probe_q < {1'b0, last_q});

  always_comb begin
    raddr = table_addr(in_first);
    case (state_q)
      S_IDLE:     raddr = table_addr(in_first);
      S_RD_LAST:  raddr = table_addr(last_q);
      S_PROBE_RD: raddr = table_addr(probe_q[IDX_W-1:0]);
      default:    raddr = table_addr(first_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      code_mem_q[table_addr(in_index)] <= in_code[SW-1:0];
    end
    rdata_q <= code_mem_q[raddr];
  end

  mss_prefix_cmp #(
    .W(SW)
  ) u_cmp (
    .base_i  (cfirst_q),
    .probe_i (rdata_q),
    .ref_i   (diff_q),
    .cmp_o   (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      last_q      <= '0;
      split_q     <= '0;
      step_q      <= '0;
      probe_q     <= '0;
      err_q       <= 1'b0;
      cfirst_q    <= '0;
      diff_q      <= '0;
      out_valid_q <= 1'b0;
      out_split_q <= '0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && (in_mode == MODE_QUERY)) begin
            first_q <= in_first;
            last_q  <= in_last;
            if (in_first > in_last) begin
              split_q <= in_first;
              err_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              // The address of the first code is on the read port now.
              err_q   <= 1'b0;
              state_q <= S_RD_LAST;
            end
          end
        end
        S_RD_LAST: begin
          cfirst_q <= rdata_q;
          state_q  <= S_CMP_END;
        end
        S_CMP_END: begin
          if (cmp.codes_equal) begin
            split_q <= mid_sum[IDX_W:1];
            state_q <= S_DONE;
          end else begin
            diff_q  <= cfirst_q ^ rdata_q;
            split_q <= first_q;
            step_q  <= last_q - first_q;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          step_q  <= step_next;
          probe_q <= {1'b0, split_q} + {1'b0, step_next};
          state_q <= S_PROBE_RD;
        end
        S_PROBE_RD: begin
          if (probe_in_range) begin
            state_q <= S_PROBE_CMP;
          end else if (step_q > IDX_W'(1)) begin
            state_q <= S_STEP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PROBE_CMP: begin
          if (cmp.longer_prefix) begin
            split_q <= probe_q[IDX_W-1:0];
          end
          state_q <= (step_q > IDX_W'(1)) ? S_STEP : S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_split_q <= split_q;
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_split_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule

// File: hw/rtl/mss_prefix_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_prefix_cmp: common-prefix comparator for Morton codes
// Tells whether two codes are equal and whether their xor has its top set
// bit below that of a reference xor, which is a leading-zero comparison
// done with two magnitude compares instead of two priority encoders.
// ----------------------------------------------------------------------------
module mss_prefix_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0]      base_i,
  input  logic [W-1:0]      probe_i,
  input  logic [W-1:0]      ref_i,
  output mss_pkg::mss_cmp_t cmp_o
);
  import mss_pkg::*;

  logic [W-1:0] diff;

  assign diff = base_i ^ probe_i;

  // The top set bit of diff lies below that of ref_i exactly when diff is
  // smaller than ref_i and also smaller than diff ^ ref_i.
  assign cmp_o.codes_equal   = (diff == '0);
  assign cmp_o.longer_prefix = (diff < ref_i) && (diff < (diff ^ ref_i));

endmodule
